[rtl/dwc_pkg.sv]
// Shared types and constants for the divider wall circle collision block.
// Holds register codes, contact codes, wall edge struct and reset values.
// No dependencies.
package dwc_pkg;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int GAP_W     = 7;
  localparam int CFG_IDX_W = 4;

  // Wall edges in whole pixels, signed (left edge may fall below zero)
  localparam int EDGE_W = 14;
  localparam int HALF_W = CFG_W - 1;

  // Opening size: (half_h * gap) / 100 via reciprocal multiply
  localparam int               PROD_W       = HALF_W + GAP_W;
  localparam int               RECIP_W      = 19;
  localparam int               RECIP_SHIFT  = 25;
  localparam logic [RECIP_W-1:0] RECIP_100  = 19'd335545;
  localparam logic [GAP_W-1:0] PERCENT_FULL = 7'd100;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] RST_CENTER_X = 12'd400;
  localparam logic [CFG_W-1:0] RST_WIDTH    = 12'd20;
  localparam logic [CFG_W-1:0] RST_HEIGHT   = 12'd600;
  localparam logic [GAP_W-1:0] RST_GAP      = 7'd20;

  // Cycles from a register write until the wall edges are current
  localparam int               SETTLE_W      = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 4'd0,
    CFG_WIDTH    = 4'd1,
    CFG_HEIGHT   = 4'd2,
    CFG_GAP      = 4'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CONTACT_NONE  = 3'd0,
    CONTACT_LEFT  = 3'd1,
    CONTACT_RIGHT = 3'd2,
    CONTACT_UPPER = 3'd3,
    CONTACT_LOWER = 3'd4
  } contact_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] right;
    logic signed [EDGE_W-1:0] up_bot;
    logic signed [EDGE_W-1:0] lo_top;
    logic signed [EDGE_W-1:0] lo_bot;
  } edges_t;

endpackage

[rtl/divider_wall_circle_collision.sv]
// Top level of the divider wall circle collision block.
// Instantiates dwc_edges and dwc_collide; depends on dwc_pkg.
//
// Tests a circular particle's predicted position against a divider wall of two
// boxes with a gap and reflects it on contact. One request is taken per clock
// while in_ready is high. An accepted request passes an input register, one
// pass of collision logic, and a result register; the input register can still
// take one request while a finished result waits.
// After reset and after every register write the wall edges are recomputed
// through a three-stage pipeline (product, reciprocal divide by 100, edges),
// and in_ready stays low for those cycles. cfg_ready is always high; write
// registers only while no request is in flight.
module divider_wall_circle_collision #(
  parameter int COORD_INT_BITS  = 12,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [dwc_pkg::CFG_IDX_W-1:0]                     cfg_index,
  input  logic [dwc_pkg::CFG_W-1:0]                         cfg_data,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  next_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  next_y,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  cur_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  cur_y,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  vel_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  vel_y,
  input  logic [15:0]                                       radius,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [2:0]                                        contact,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  out_x,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  out_y,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  out_vel_x,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  out_vel_y
);
  import dwc_pkg::*;

  localparam int CW = COORD_INT_BITS + COORD_FRAC_BITS;

  logic                 cfg_we;
  logic [SETTLE_W-1:0]  settle;
  edges_t               edges;

  logic                 s1_valid;
  logic signed [CW-1:0] s1_next_x, s1_next_y, s1_cur_x, s1_cur_y, s1_vel_x, s1_vel_y;
  logic [15:0]          s1_radius;
  logic                 in_take;
  logic                 s1_move;

  contact_t             res_contact;
  logic signed [CW-1:0] res_x, res_y, res_vel_x, res_vel_y;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  dwc_edges u_edges (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .edges     (edges)
  );

  // Hold off requests until the edge pipeline has caught up
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  // Advance the input register when the result register is free or draining
  assign s1_move  = s1_valid & (~out_valid | out_ready);
  assign in_ready = (settle == '0) & (~s1_valid | ~out_valid | out_ready);
  assign in_take  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_next_x <= next_x;
      s1_next_y <= next_y;
      s1_cur_x  <= cur_x;
      s1_cur_y  <= cur_y;
      s1_vel_x  <= vel_x;
      s1_vel_y  <= vel_y;
      s1_radius <= radius;
    end
  end

  dwc_collide #(
    .COORD_INT_BITS  (COORD_INT_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_collide (
    .edges     (edges),
    .next_x    (s1_next_x),
    .next_y    (s1_next_y),
    .cur_x     (s1_cur_x),
    .cur_y     (s1_cur_y),
    .vel_x     (s1_vel_x),
    .vel_y     (s1_vel_y),
    .radius    (s1_radius),
    .contact   (res_contact),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_vel_x (res_vel_x),
    .out_vel_y (res_vel_y)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      contact   <= res_contact;
      out_x     <= res_x;
      out_y     <= res_y;
      out_vel_x <= res_vel_x;
      out_vel_y <= res_vel_y;
    end
  end

endmodule

[rtl/dwc_edges.sv]
// Configuration registers and wall edge computation.
// Edges pass product, quotient and edge registers. Depends on dwc_pkg.
module dwc_edges (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dwc_pkg::CFG_W-1:0]       cfg_data,
  output dwc_pkg::edges_t                 edges
);
  import dwc_pkg::*;

  localparam int OPEN_W = HALF_W;
  localparam int QW     = PROD_W + RECIP_W;

  logic [CFG_W-1:0]  center_x;
  logic [CFG_W-1:0]  wall_width;
  logic [CFG_W-1:0]  wall_height;
  logic [GAP_W-1:0]  gap;
  logic [PROD_W-1:0] prod;
  logic [OPEN_W-1:0] open_px;
  logic [QW-1:0]     quot_full;
  edges_t            edges_next;

  logic [HALF_W-1:0] half_w;
  logic [HALF_W-1:0] half_h;
  logic [GAP_W-1:0]  gap_data;

  assign half_w   = wall_width[CFG_W-1:1];
  assign half_h   = wall_height[CFG_W-1:1];
  assign gap_data = cfg_data[GAP_W-1:0];

  // Write registers; drop gap values above full scale
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= RST_CENTER_X;
      wall_width  <= RST_WIDTH;
      wall_height <= RST_HEIGHT;
      gap         <= RST_GAP;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X: center_x    <= cfg_data;
        CFG_WIDTH:    wall_width  <= cfg_data;
        CFG_HEIGHT:   wall_height <= cfg_data;
        CFG_GAP: begin
          if (gap_data <= PERCENT_FULL) gap <= gap_data;
        end
        default: ;
      endcase
    end
  end

  // Opening: half height times percent, then divide by 100 via reciprocal
  assign quot_full = QW'(prod) * QW'(RECIP_100);

  always_ff @(posedge clk) begin
    prod    <= PROD_W'(half_h) * PROD_W'(gap);
    open_px <= quot_full[RECIP_SHIFT +: OPEN_W];
  end

  // Box edges in whole pixels
  always_comb begin
    edges_next.left   = EDGE_W'(center_x) - EDGE_W'(half_w);
    edges_next.right  = EDGE_W'(center_x) + EDGE_W'(half_w);
    edges_next.up_bot = EDGE_W'(half_h) - EDGE_W'(open_px);
    edges_next.lo_top = EDGE_W'(half_h) + EDGE_W'(open_px);
    edges_next.lo_bot = EDGE_W'(wall_height);
  end

  always_ff @(posedge clk) begin
    edges <= edges_next;
  end

endmodule

[rtl/dwc_collide.sv]
// Collision test of one particle against the two wall boxes, combinational.
// Picks the nearest face, clamps position and reflects velocity. Depends on dwc_pkg.
module dwc_collide #(
  parameter int COORD_INT_BITS  = 12,
  parameter int COORD_FRAC_BITS = 8
) (
  input  dwc_pkg::edges_t                                    edges,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   next_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   next_y,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   cur_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   cur_y,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   vel_x,
  input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   vel_y,
  input  logic [15:0]                                        radius,
  output dwc_pkg::contact_t                                  contact,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   out_x,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   out_y,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   out_vel_x,
  output logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]   out_vel_y
);
  import dwc_pkg::*;

  localparam int CW   = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int EW_A = (CW > EDGE_W + COORD_FRAC_BITS) ? CW : EDGE_W + COORD_FRAC_BITS;
  localparam int EW   = ((EW_A > 17) ? EW_A : 17) + 2;
  localparam logic signed [EW-1:0] CMAX = (EW'(1) <<< (CW - 1)) - EW'(1);
  localparam logic signed [EW-1:0] CMIN = -CMAX - EW'(1);
  localparam logic [CW-1:0]        VMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0]        VMAX = {1'b0, {(CW-1){1'b1}}};

  function automatic logic signed [CW-1:0] sat_c(input logic signed [EW-1:0] v);
    logic signed [CW-1:0] res;
    if (v > CMAX)      res = CMAX[CW-1:0];
    else if (v < CMIN) res = CMIN[CW-1:0];
    else               res = v[CW-1:0];
    return res;
  endfunction

  function automatic logic signed [EW-1:0] abs_e(input logic signed [EW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [CW-1:0] neg_c(input logic signed [CW-1:0] v);
    return (v == VMIN) ? VMAX : -v;
  endfunction

  // Left beats right beats the horizontal face on ties
  function automatic contact_t nearest(input logic signed [EW-1:0] dl,
                                       input logic signed [EW-1:0] dr,
                                       input logic signed [EW-1:0] dh,
                                       input contact_t horiz);
    contact_t res;
    if (dl <= dr) res = (dl <= dh) ? CONTACT_LEFT : horiz;
    else          res = (dr <= dh) ? CONTACT_RIGHT : horiz;
    return res;
  endfunction

  logic signed [EW-1:0] nx, ny, r;
  logic signed [EW-1:0] left_f, right_f, up_bot_f, lo_top_f, lo_bot_f;
  logic signed [EW-1:0] dl, dr;
  logic                 x_in, hit_up, hit_lo;

  // Scale pixel edges into fixed point
  always_comb begin
    nx       = EW'(next_x);
    ny       = EW'(next_y);
    r        = EW'({1'b0, radius});
    left_f   = EW'(edges.left)   <<< COORD_FRAC_BITS;
    right_f  = EW'(edges.right)  <<< COORD_FRAC_BITS;
    up_bot_f = EW'(edges.up_bot) <<< COORD_FRAC_BITS;
    lo_top_f = EW'(edges.lo_top) <<< COORD_FRAC_BITS;
    lo_bot_f = EW'(edges.lo_bot) <<< COORD_FRAC_BITS;
  end

  // Overlap tests, upper box first
  always_comb begin
    x_in   = (nx + r >= left_f) && (nx - r <= right_f);
    hit_up = x_in && (ny + r >= EW'(0)) && (ny - r <= up_bot_f);
    hit_lo = x_in && (ny + r >= lo_top_f) && (ny - r <= lo_bot_f);
    dl     = abs_e(nx - left_f);
    dr     = abs_e(nx - right_f);
  end

  // Pick the face, clamp and reflect
  always_comb begin
    if (hit_up)      contact = nearest(dl, dr, abs_e(ny - up_bot_f), CONTACT_UPPER);
    else if (hit_lo) contact = nearest(dl, dr, abs_e(ny - lo_top_f), CONTACT_LOWER);
    else             contact = CONTACT_NONE;

    out_x     = cur_x;
    out_y     = cur_y;
    out_vel_x = vel_x;
    out_vel_y = vel_y;
    case (contact)
      CONTACT_LEFT: begin
        out_x     = sat_c(left_f - r);
        out_vel_x = neg_c(vel_x);
      end
      CONTACT_RIGHT: begin
        out_x     = sat_c(right_f + r);
        out_vel_x = neg_c(vel_x);
      end
      CONTACT_UPPER: begin
        out_y     = sat_c(up_bot_f + r);
        out_vel_y = neg_c(vel_y);
      end
      CONTACT_LOWER: begin
        out_y     = sat_c(lo_top_f - r);
        out_vel_y = neg_c(vel_y);
      end
      default: ;
    endcase
  end

endmodule

[rtl/dwc_checker.sv]
// Port-level checks for divider_wall_circle_collision, attached by bind.
// Depends on dwc_pkg.
module dwc_checker #(
  parameter int COORD_INT_BITS  = 12,
  parameter int COORD_FRAC_BITS = 8
) (
  input logic                                              clk,
  input logic                                              rst,
  input logic                                              cfg_valid,
  input logic                                              cfg_ready,
  input logic                                              in_ready,
  input logic                                              out_valid,
  input logic                                              out_ready,
  input logic [2:0]                                        contact,
  input logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  out_x,
  input logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  out_y,
  input logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  out_vel_x,
  input logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  out_vel_y
);
  import dwc_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(contact) && $stable(out_x)
      && $stable(out_y) && $stable(out_vel_x) && $stable(out_vel_y))
    else $error("stalled result changed");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A register write blocks requests while the edges settle
  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("request taken while wall edges settle");

  // Only defined contact codes leave the block
  a_contact_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> contact == CONTACT_NONE || contact == CONTACT_LEFT
      || contact == CONTACT_RIGHT || contact == CONTACT_UPPER
      || contact == CONTACT_LOWER)
    else $error("undefined contact code");

endmodule

bind divider_wall_circle_collision dwc_checker #(
  .COORD_INT_BITS  (COORD_INT_BITS),
  .COORD_FRAC_BITS (COORD_FRAC_BITS)
) u_dwc_checker (.*);

[sim/divider_wall_circle_collision_tb.sv]
// Self-checking bench for divider_wall_circle_collision: drives particles and wall
// settings and compares each reflected result with a local bounce predictor.
// Depends on rtl/dwc_pkg.sv and rtl/divider_wall_circle_collision.sv.
`timescale 1ns / 100ps

module divider_wall_circle_collision_tb;
  import dwc_pkg::*;

  localparam int     COORD_W    = 20;
  localparam int     CLK_PERIOD = 10;
  localparam longint SCALE      = 256;
  localparam longint COORD_MAX  = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN  = -(longint'(1) << (COORD_W - 1));
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd12;
  localparam int     NUM_PHASES = 6;
  localparam int     RANDOM_PER_PHASE = 72;

  typedef struct packed {
    logic signed [COORD_W-1:0] next_x;
    logic signed [COORD_W-1:0] next_y;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
    logic [15:0]               radius;
  } particle_t;

  typedef struct packed {
    logic [2:0]                contact;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
  } bounce_t;

  // Wall settings, bounce predictor and queue of predicted bounces
  class wall_hit_checker;
    logic [CFG_W-1:0] center_x;
    logic [CFG_W-1:0] wall_w;
    logic [CFG_W-1:0] wall_h;
    logic [GAP_W-1:0] gap_pct;
    bounce_t          pending_bounces[$];
    int               errors;
    int               checked;
    int               contact_seen[5];

    function new();
      center_x = RST_CENTER_X;
      wall_w   = RST_WIDTH;
      wall_h   = RST_HEIGHT;
      gap_pct  = RST_GAP;
      errors   = 0;
      checked  = 0;
      foreach (contact_seen[i]) contact_seen[i] = 0;
    endfunction

    static function longint clamp(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
    endfunction

    static function longint gap_to(longint v);
      return v < 0 ? -v : v;
    endfunction

    // Left wins ties, then right, then the horizontal face
    static function contact_t nearest(longint dl, longint dr, longint dh);
      if (dl <= dr) return dl <= dh ? CONTACT_LEFT : CONTACT_UPPER;
      return dr <= dh ? CONTACT_RIGHT : CONTACT_UPPER;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_CENTER_X: center_x = data;
        CFG_WIDTH:    wall_w = data;
        CFG_HEIGHT:   wall_h = data;
        CFG_GAP: begin
          // drop gap values above full scale
          if (data[GAP_W-1:0] <= PERCENT_FULL) gap_pct = data[GAP_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function void wall_edges(output longint l, output longint rt, output longint ub,
                             output longint lt, output longint lb);
      longint hw, hh, opening;
      hw      = longint'(wall_w) / 2;
      hh      = longint'(wall_h) / 2;
      opening = (hh * longint'(gap_pct)) / 100;
      l  = (longint'(center_x) - hw) * SCALE;
      rt = (longint'(center_x) + hw) * SCALE;
      ub = (hh - opening) * SCALE;
      lt = (hh + opening) * SCALE;
      lb = longint'(wall_h) * SCALE;
    endfunction

    function bounce_t bounce(particle_t p);
      longint   nx, ny, cx, cy, vx, vy, rad, l, rt, ub, lt, lb;
      bit       x_in;
      contact_t face;
      bounce_t  res;
      nx  = p.next_x;
      ny  = p.next_y;
      cx  = p.cur_x;
      cy  = p.cur_y;
      vx  = p.vel_x;
      vy  = p.vel_y;
      rad = p.radius;
      wall_edges(l, rt, ub, lt, lb);
      x_in = (nx + rad >= l) && (nx - rad <= rt);
      face = CONTACT_NONE;
      // upper box first, then lower box
      if (x_in && ny + rad >= 0 && ny - rad <= ub) begin
        face = nearest(gap_to(nx - l), gap_to(nx - rt), gap_to(ny - ub));
        if (face == CONTACT_UPPER) cy = clamp(ub + rad);
      end else if (x_in && ny + rad >= lt && ny - rad <= lb) begin
        face = nearest(gap_to(nx - l), gap_to(nx - rt), gap_to(ny - lt));
        if (face == CONTACT_UPPER) begin
          face = CONTACT_LOWER;
          cy   = clamp(lt - rad);
        end
      end
      // clamp the contact axis and reflect its velocity
      case (face)
        CONTACT_LEFT: begin
          cx = clamp(l - rad);
          vx = clamp(-vx);
        end
        CONTACT_RIGHT: begin
          cx = clamp(rt + rad);
          vx = clamp(-vx);
        end
        CONTACT_UPPER, CONTACT_LOWER: vy = clamp(-vy);
        default: ;
      endcase
      res.contact = face;
      res.x       = cx[COORD_W-1:0];
      res.y       = cy[COORD_W-1:0];
      res.vel_x   = vx[COORD_W-1:0];
      res.vel_y   = vy[COORD_W-1:0];
      return res;
    endfunction

    function void note_request(particle_t p);
      pending_bounces.push_back(bounce(p));
    endfunction

    function int pending();
      return pending_bounces.size();
    endfunction

    function void check_result(bounce_t got);
      bounce_t want;
      if (pending_bounces.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with no request outstanding, contact=%0d x=%0d y=%0d",
                   got.contact, got.x, got.y);
        return;
      end
      want = pending_bounces.pop_front();
      checked++;
      if (want.contact < 5) contact_seen[want.contact]++;
      if (got.contact !== want.contact || got.x !== want.x || got.y !== want.y ||
          got.vel_x !== want.vel_x || got.vel_y !== want.vel_y) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d expected contact=%0d x=%0d y=%0d vx=%0d vy=%0d",
                   checked, want.contact, want.x, want.y, want.vel_x, want.vel_y);
          $display("       got contact=%0d x=%0d y=%0d vx=%0d vy=%0d",
                   got.contact, got.x, got.y, got.vel_x, got.vel_y);
        end
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] next_x = '0;
  logic signed [COORD_W-1:0] next_y = '0;
  logic signed [COORD_W-1:0] cur_x = '0;
  logic signed [COORD_W-1:0] cur_y = '0;
  logic signed [COORD_W-1:0] vel_x = '0;
  logic signed [COORD_W-1:0] vel_y = '0;
  logic [15:0]               radius = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [2:0]                contact;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_vel_x;
  logic signed [COORD_W-1:0] out_vel_y;

  wall_hit_checker board;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int results_seen = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int requests_sent = 0;
  int settings_run  = 0;

  divider_wall_circle_collision dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .next_x    (next_x),
    .next_y    (next_y),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .radius    (radius),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .contact   (contact),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_vel_x (out_vel_x),
    .out_vel_y (out_vel_y)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 40) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= 150;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result({contact, out_x, out_y, out_vel_x, out_vel_y});
      results_seen <= results_seen + 1;
    end
  end

  function automatic longint pick_signed(longint span);
    return longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  function automatic particle_t mk_particle(longint nx, longint ny, longint rad,
                                            longint vx, longint vy);
    particle_t p;
    p.next_x = COORD_W'(wall_hit_checker::clamp(nx));
    p.next_y = COORD_W'(wall_hit_checker::clamp(ny));
    p.cur_x  = COORD_W'($urandom);
    p.cur_y  = COORD_W'($urandom);
    p.vel_x  = COORD_W'(vx);
    p.vel_y  = COORD_W'(vy);
    p.radius = 16'(rad);
    return p;
  endfunction

  // Aim most particles at the wall faces and corners; the rest are noise
  function automatic particle_t aim_particle();
    particle_t p;
    longint    l, rt, ub, lt, lb, ax, ay, rad, span, nx, ny, vx, vy;
    int        pick;
    board.wall_edges(l, rt, ub, lt, lb);
    if ($urandom_range(99) < 12) begin
      p.next_x = COORD_W'($urandom);
      p.next_y = COORD_W'($urandom);
      p.cur_x  = COORD_W'($urandom);
      p.cur_y  = COORD_W'($urandom);
      p.vel_x  = COORD_W'($urandom);
      p.vel_y  = COORD_W'($urandom);
      p.radius = 16'($urandom);
      return p;
    end
    pick = $urandom_range(19);
    if (pick < 2) rad = 0;
    else if (pick < 4) rad = 65535;
    else if (pick < 7) rad = $urandom_range(65535);
    else rad = $urandom_range(4095);
    case ($urandom_range(3))
      0: ax = l;
      1: ax = rt;
      2: ax = (l + rt) / 2;
      default: ax = pick_signed(COORD_MAX);
    endcase
    case ($urandom_range(5))
      0: ay = 0;
      1: ay = ub;
      2: ay = lt;
      3: ay = lb;
      4: ay = (ub + lt) / 2;
      default: ay = $urandom_range(32'(lb));
    endcase
    span = rad + 3072;
    nx   = ax + pick_signed(span);
    // sometimes sit on the diagonal to force equal face distances
    if ($urandom_range(9) == 0)
      ny = ay + ($urandom_range(1) ? 1 : -1) * wall_hit_checker::gap_to(nx - ax);
    else
      ny = ay + pick_signed(span);
    pick = $urandom_range(19);
    vx = (pick == 0) ? COORD_MIN : (pick == 1) ? COORD_MAX : pick_signed(COORD_MAX);
    pick = $urandom_range(19);
    vy = (pick == 0) ? COORD_MIN : (pick == 1) ? COORD_MAX : pick_signed(COORD_MAX);
    return mk_particle(nx, ny, rad, vx, vy);
  endfunction

  // Offer one request, with random idle cycles ahead of it
  task automatic send_particle(input particle_t p);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    next_x   <= p.next_x;
    next_y   <= p.next_y;
    cur_x    <= p.cur_x;
    cur_y    <= p.cur_y;
    vel_x    <= p.vel_x;
    vel_y    <= p.vel_y;
    radius   <= p.radius;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(p);
    requests_sent++;
  endtask

  // Leave cfg_valid high; the caller drops it after the last write
  task automatic write_wall_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Drain all outstanding requests before touching the wall registers
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_wall(input int phase);
    case (phase)
      1: begin
        write_wall_reg(CFG_CENTER_X, 12'd0);
        write_wall_reg(CFG_WIDTH, 12'd4095);
        write_wall_reg(CFG_HEIGHT, 12'd4095);
        write_wall_reg(CFG_GAP, 12'd0);
        write_wall_reg(CFG_GAP, 12'd101);
      end
      2: begin
        write_wall_reg(CFG_CENTER_X, 12'd4095);
        write_wall_reg(CFG_GAP, 12'd100);
        write_wall_reg(CFG_GAP, 12'd127);
      end
      3: begin
        write_wall_reg(CFG_CENTER_X, 12'd200);
        write_wall_reg(CFG_WIDTH, 12'd7);
        write_wall_reg(CFG_HEIGHT, 12'd1);
        write_wall_reg(CFG_GAP, 12'hFC8);
        write_wall_reg(CFG_SPARE, CFG_W'($urandom));
      end
      4: begin
        write_wall_reg(CFG_CENTER_X, CFG_W'($urandom_range(2047)));
        write_wall_reg(CFG_WIDTH, CFG_W'($urandom));
        write_wall_reg(CFG_HEIGHT, CFG_W'($urandom));
        write_wall_reg(CFG_GAP, CFG_W'($urandom));
      end
      default: begin
        write_wall_reg(CFG_CENTER_X, 12'd400);
        write_wall_reg(CFG_WIDTH, 12'd21);
        write_wall_reg(CFG_HEIGHT, 12'd600);
        write_wall_reg(CFG_GAP, 12'd20);
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Faces, ties, grazing contacts and field extremes on the reset wall
  task automatic run_directed();
    longint l, rt, ub, lt, lb, mid;
    board.wall_edges(l, rt, ub, lt, lb);
    mid = (l + rt) / 2;
    send_particle(mk_particle(0, 0, 0, 1000, -1000));
    send_particle(mk_particle(l + 256, 100 * SCALE, 512, 5000, 77));
    send_particle(mk_particle(rt - 256, 100 * SCALE, 512, -5000, 77));
    send_particle(mk_particle(mid, ub - 100, 256, 300, 4000));
    send_particle(mk_particle(mid, lt + 100, 256, 300, -4000));
    send_particle(mk_particle(mid, (ub + lt) / 2, 256, 300, 300));
    send_particle(mk_particle(mid, 100 * SCALE, 128, 900, 900));
    send_particle(mk_particle(l + 512, ub - 512, 0, 900, 900));
    send_particle(mk_particle(rt - 512, ub + 512, 1024, 900, 900));
    send_particle(mk_particle(l + 512, lt + 512, 0, 900, 900));
    send_particle(mk_particle(l + 256, 100 * SCALE, 512, COORD_MIN, COORD_MIN));
    send_particle(mk_particle(mid, ub - 100, 256, COORD_MIN, COORD_MIN));
    send_particle(mk_particle(COORD_MAX, COORD_MAX, 65535, COORD_MAX, COORD_MAX));
    send_particle(mk_particle(COORD_MIN, COORD_MIN, 0, COORD_MIN, COORD_MIN));
    send_particle(mk_particle(mid, -65535, 65535, 12, 34));
    send_particle(mk_particle(l - 512, 128 * SCALE, 512, 12, 34));
    send_particle(mk_particle(mid, lb + 256, 256, 12, 34));
    send_particle(mk_particle(l - 513, 128 * SCALE, 512, 12, 34));
  endtask

  // Stimulus: six wall settings, with idle pattern stepping through phases
  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 2) begin
        tx_gap_pct   = 16;
        rx_stall_pct = 56;
      end else if (phase < 4) begin
        tx_gap_pct   = 56;
        rx_stall_pct = 16;
      end else begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      if (phase != 0) begin
        settle_idle();
        program_wall(phase);
      end else begin
        run_directed();
      end
      repeat (RANDOM_PER_PHASE) send_particle(aim_particle());
      settings_run++;
    end
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d requests over %0d wall settings, %0d results checked",
             requests_sent, settings_run, board.checked);
    $display("Contacts: none %0d, left %0d, right %0d, upper %0d, lower %0d",
             board.contact_seen[0], board.contact_seen[1], board.contact_seen[2],
             board.contact_seen[3], board.contact_seen[4]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", board.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
